// File: sv/swgc_pkg.sv
// ---------------------------------------------------------------------------
// swgc_pkg
// Shared constants and per-nucleotide weight functions for the GC window.
// ---------------------------------------------------------------------------
package swgc_pkg;

    localparam int MAX_HALF    = 63;
    localparam int RING_DEPTH  = 128;
    localparam int POS_BITS    = 24;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int HALF_RESET  = 24;

    // divider jobs, in the order they run for one result
    localparam logic [2:0] JOB_LVL = 3'd0;
    localparam logic [2:0] JOB_F0  = 3'd1;
    localparam logic [2:0] JOB_F1  = 3'd2;
    localparam logic [2:0] JOB_F2  = 3'd3;
    localparam logic [2:0] JOB_TS  = 3'd4;
    localparam logic [2:0] JOB_AS  = 3'd5;

    // GC fraction of one mask in twelfths
    function automatic logic [3:0] gc_twelfths(input logic [3:0] c);
        logic [1:0] g;
        logic [2:0] n;
        logic [3:0] r;
        g = 2'(c[1]) + 2'(c[2]);
        n = 3'(g) + 3'(c[0]) + 3'(c[3]);
        case (n)
            3'd1:    r = (g == 2'd1) ? 4'd12 : 4'd0;
            3'd2:    r = (g == 2'd2) ? 4'd12 : ((g == 2'd1) ? 4'd6 : 4'd0);
            3'd3:    r = (g == 2'd2) ? 4'd8 : ((g == 2'd1) ? 4'd4 : 4'd0);
            3'd4:    r = 4'd6;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] a_halves(input logic [3:0] c);
        return c[0] ? (c[3] ? 2'd1 : 2'd2) : 2'd0;
    endfunction

    function automatic logic [1:0] t_halves(input logic [3:0] c);
        return c[3] ? (c[0] ? 2'd1 : 2'd2) : 2'd0;
    endfunction

endpackage

// File: sv/sliding_window_gc_content_top.sv
// ---------------------------------------------------------------------------
// sliding_window_gc_content_top
// Sliding-window GC content and A/T shares over a nucleotide stream.
// ---------------------------------------------------------------------------
// Each accepted nucleotide is stored in a 128-entry ring memory and added to
// running sums; position i is reported once nucleotide i+h has arrived, and
// the last nucleotide (seq_end) flushes all remaining positions. Reporting a
// position reads the leaving nucleotide from the ring, loads the divider, then
// runs six divisions (GC level, three frames, two A/T shares) on one shared
// restoring divider, 16 quotient bits each at one bit per cycle. The result
// item is then presented and held until taken. New nucleotides are accepted
// only while no position is being reported, so a waiting output holds the input.
// h is latched at the first item of each sequence.
module sliding_window_gc_content_top import swgc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [3:0]          i_base_code,
    input  logic                i_seq_end,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [5:0]          i_cfg_data,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [POS_BITS-1:0] o_position,
    output logic signed [15:0]  o_gc_level,
    output logic [15:0]         o_gc_frame_zero,
    output logic [15:0]         o_gc_frame_one,
    output logic [15:0]         o_gc_frame_two,
    output logic [14:0]         o_t_share,
    output logic [14:0]         o_a_share,
    output logic                o_no_at,
    output logic                o_final_result
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_READ, S_LOAD, S_DIV, S_OUT
    } t_state;

    logic [3:0] r_ring [RING_DEPTH];
    logic [3:0] r_rd_data;

    t_state            r_state;
    logic [5:0]        r_half_cfg, r_act_half;
    logic [9:0]        r_fsum [3];
    logic [7:0]        r_asum, r_tsum;
    logic [6:0]        r_wcount;
    logic [RING_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_wr_phase, r_rd_phase;
    logic [6:0]        r_pending, r_emitted;
    logic [POS_BITS-1:0] r_emit_pos;
    logic              r_end, r_flush, r_last;

    // divider
    logic [2:0]  r_job;
    logic [3:0]  r_bit;
    logic [25:0] r_rem;
    logic [8:0]  r_den;
    logic [15:0] r_quo;

    logic [15:0] r_lvl, r_f0, r_f1, r_f2;
    logic [14:0] r_ts, r_as;
    logic        r_noat;

    logic [11:0] s_sum;
    logic [8:0]  s_at;
    assign s_sum = 12'(r_fsum[0]) + 12'(r_fsum[1]) + 12'(r_fsum[2]);
    assign s_at  = 9'(r_asum) + 9'(r_tsum);

    // numerator scaled so that quotient = floor(x * scale / den)
    function automatic logic [25:0] job_num(input logic [2:0] j, input logic [11:0] s,
                                            input logic [9:0] f0, input logic [9:0] f1,
                                            input logic [9:0] f2, input logic [7:0] ts,
                                            input logic [7:0] as_);
        case (j)
            JOB_LVL: return 26'(s) << 11;
            JOB_F0:  return 26'(f0) << 12;
            JOB_F1:  return 26'(f1) << 12;
            JOB_F2:  return 26'(f2) << 12;
            JOB_TS:  return 26'(ts) << 14;
            default: return 26'(as_) << 14;
        endcase
    endfunction

    logic [26:0] s_trial;
    logic [25:0] s_rem_next;
    logic [15:0] s_quo_next;
    logic [2:0]  s_next_job;
    logic [8:0]  s_next_den;
    assign s_trial    = {1'b0, r_rem} - (27'(r_den) << r_bit);
    assign s_rem_next = s_trial[26] ? r_rem : s_trial[25:0];
    assign s_quo_next = s_trial[26] ? r_quo : (r_quo | (16'd1 << r_bit));
    assign s_next_job = r_job + 3'd1;
    assign s_next_den = (s_next_job < JOB_TS) ? 9'(r_wcount) : s_at;

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_ring[r_wr_ptr] <= i_base_code;
        end
        r_rd_data <= r_ring[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_half_cfg <= 6'(HALF_RESET);
            r_act_half <= 6'(HALF_RESET);
            r_fsum[0]  <= '0; r_fsum[1] <= '0; r_fsum[2] <= '0;
            r_asum     <= '0; r_tsum <= '0; r_wcount <= '0;
            r_wr_ptr   <= '0; r_rd_ptr <= '0;
            r_wr_phase <= '0; r_rd_phase <= '0;
            r_pending  <= '0; r_emitted <= '0;
            r_emit_pos <= '0;
            r_end      <= 1'b0; r_flush <= 1'b0; r_last <= 1'b0;
            o_valid    <= 1'b0;
            r_job      <= '0; r_bit <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) r_half_cfg <= i_cfg_data;
                    if (i_valid) begin
                        if (r_pending == 7'd0 && r_emitted == 7'd0) begin
                            r_act_half <= (r_half_cfg == 6'd0) ? 6'd1 : r_half_cfg;
                        end
                        r_wr_ptr   <= r_wr_ptr + RING_AW'(1);
                        r_wr_phase <= (r_wr_phase == 2'd2) ? 2'd0 : r_wr_phase + 2'd1;
                        r_fsum[r_wr_phase] <= r_fsum[r_wr_phase] + 10'(gc_twelfths(i_base_code));
                        r_asum     <= r_asum + 8'(a_halves(i_base_code));
                        r_tsum     <= r_tsum + 8'(t_halves(i_base_code));
                        r_wcount   <= r_wcount + 7'd1;
                        r_pending  <= r_pending + 7'd1;
                        r_end      <= i_seq_end;
                        r_flush    <= 1'b0;
                        r_state    <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    // normal emit, then flush positions on the last item
                    if (!r_flush && r_pending > 7'(r_act_half)) begin
                        r_flush <= 1'b1;
                        r_last  <= 1'b0;
                        r_state <= S_READ;
                    end else if (r_end && r_pending != 7'd0) begin
                        r_flush <= 1'b1;
                        r_last  <= (r_pending == 7'd1);
                        r_state <= S_READ;
                    end else begin
                        if (r_end) begin
                            r_fsum[0] <= '0; r_fsum[1] <= '0; r_fsum[2] <= '0;
                            r_asum <= '0; r_tsum <= '0; r_wcount <= '0;
                            r_wr_ptr <= '0; r_rd_ptr <= '0;
                            r_wr_phase <= '0; r_rd_phase <= '0;
                            r_pending <= '0; r_emitted <= '0; r_emit_pos <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    // ring data for r_rd_ptr is valid now
                    if (r_emitted >= 7'(r_act_half)) begin
                        r_fsum[r_rd_phase] <= (r_fsum[r_rd_phase] > 10'(gc_twelfths(r_rd_data)))
                            ? r_fsum[r_rd_phase] - 10'(gc_twelfths(r_rd_data)) : 10'd0;
                        r_asum <= (r_asum > 8'(a_halves(r_rd_data)))
                            ? r_asum - 8'(a_halves(r_rd_data)) : 8'd0;
                        r_tsum <= (r_tsum > 8'(t_halves(r_rd_data)))
                            ? r_tsum - 8'(t_halves(r_rd_data)) : 8'd0;
                        r_wcount <= (r_wcount != 7'd0) ? r_wcount - 7'd1 : 7'd0;
                        r_rd_ptr <= r_rd_ptr + RING_AW'(1);
                        r_rd_phase <= (r_rd_phase == 2'd2) ? 2'd0 : r_rd_phase + 2'd1;
                    end
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    // sums are settled; start the first division
                    r_job   <= JOB_LVL;
                    r_bit   <= 4'd15;
                    r_quo   <= '0;
                    r_rem   <= job_num(JOB_LVL, s_sum, r_fsum[0], r_fsum[1], r_fsum[2],
                                       r_tsum, r_asum);
                    r_den   <= 9'(r_wcount);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_bit != 4'd0) begin
                        r_rem <= s_rem_next;
                        r_quo <= s_quo_next;
                        r_bit <= r_bit - 4'd1;
                    end else begin
                        case (r_job)
                            JOB_LVL: r_lvl <= s_quo_next - 16'd4096;
                            JOB_F0:  r_f0  <= s_quo_next;
                            JOB_F1:  r_f1  <= s_quo_next;
                            JOB_F2:  r_f2  <= s_quo_next;
                            JOB_TS:  r_ts  <= s_quo_next[14:0];
                            default: r_as  <= s_quo_next[14:0];
                        endcase
                        if (r_job == JOB_AS) begin
                            r_state <= S_OUT;
                        end else begin
                            // load the next job
                            r_job <= s_next_job;
                            r_bit <= 4'd15;
                            r_quo <= '0;
                            r_rem <= job_num(s_next_job, s_sum, r_fsum[0], r_fsum[1],
                                             r_fsum[2], r_tsum, r_asum);
                            r_den <= s_next_den;
                        end
                    end
                end
                S_OUT: begin
                    if (!o_valid) begin
                        o_valid <= 1'b1;
                        r_noat  <= (s_at == 9'd0);
                    end else if (i_ready) begin
                        o_valid    <= 1'b0;
                        r_emit_pos <= r_emit_pos + POS_BITS'(1);
                        if (r_emitted != 7'd127) r_emitted <= r_emitted + 7'd1;
                        if (r_pending != 7'd0) r_pending <= r_pending - 7'd1;
                        r_state    <= S_DECIDE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_position      = r_emit_pos;
    assign o_gc_level      = (r_wcount == 7'd0) ? -16'sd4096 : $signed(r_lvl);
    assign o_gc_frame_zero = (r_wcount == 7'd0) ? 16'd0 : r_f0;
    assign o_gc_frame_one  = (r_wcount == 7'd0) ? 16'd0 : r_f1;
    assign o_gc_frame_two  = (r_wcount == 7'd0) ? 16'd0 : r_f2;
    assign o_t_share       = r_noat ? 15'd0 : r_ts;
    assign o_a_share       = r_noat ? 15'd0 : r_as;
    assign o_no_at         = r_noat;
    assign o_final_result  = r_last;

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT)) else $error("result outside output state");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_position) && $stable(o_gc_level)))
        else $error("result item changed while waiting");
`endif

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the sliding-window GC content block.
// ---------------------------------------------------------------------------
// Drives nucleotide sequences through the valid/ready input channel, keeps a
// cycle-free predictor of the window sums, and compares every result item
// field by field in order. Half-window settings change only while idle.
// ---------------------------------------------------------------------------
module tb;
    import swgc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 5000;
    localparam int DRAIN_WAIT = 200;

    typedef struct {
        logic [POS_BITS-1:0] position;
        logic signed [15:0]  gc_level;
        logic [15:0]         frame0;
        logic [15:0]         frame1;
        logic [15:0]         frame2;
        logic [14:0]         t_share;
        logic [14:0]         a_share;
        logic                no_at;
        logic                last;
    } t_window_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    logic [3:0]          i_base_code;
    logic                i_seq_end;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [5:0]          i_cfg_data;
    logic                o_valid;
    logic                i_ready;
    logic [POS_BITS-1:0] o_position;
    logic signed [15:0]  o_gc_level;
    logic [15:0]         o_gc_frame_zero;
    logic [15:0]         o_gc_frame_one;
    logic [15:0]         o_gc_frame_two;
    logic [14:0]         o_t_share;
    logic [14:0]         o_a_share;
    logic                o_no_at;
    logic                o_final_result;

    sliding_window_gc_content_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_base_code     (i_base_code),
        .i_seq_end       (i_seq_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_position      (o_position),
        .o_gc_level      (o_gc_level),
        .o_gc_frame_zero (o_gc_frame_zero),
        .o_gc_frame_one  (o_gc_frame_one),
        .o_gc_frame_two  (o_gc_frame_two),
        .o_t_share       (o_t_share),
        .o_a_share       (o_a_share),
        .o_no_at         (o_no_at),
        .o_final_result  (o_final_result)
    );

    t_window_result expected_q[$];
    int             n_errors = 0;
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             stall_cycles = 0;

    // predictor state
    logic [3:0]  base_ring [RING_DEPTH];
    int unsigned frame_gc [3];
    int unsigned a_halves_sum, t_halves_sum, win_count, emit_pos;
    int unsigned wr_idx, rd_idx, wr_frame, rd_frame, n_pending, n_emitted;
    int unsigned live_half, half_reg;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int unsigned gc_weight(logic [3:0] c);
        int unsigned g, n;
        g = c[1] + c[2];
        n = g + c[0] + c[3];
        return (n == 0) ? 0 : (g * 12) / n;
    endfunction

    function automatic int unsigned a_weight(logic [3:0] c);
        return c[0] ? (c[3] ? 1 : 2) : 0;
    endfunction

    function automatic int unsigned t_weight(logic [3:0] c);
        return c[3] ? (c[0] ? 1 : 2) : 0;
    endfunction

    function automatic int unsigned dec_floor(int unsigned x, int unsigned y);
        return (x > y) ? x - y : 0;
    endfunction

    function automatic void clear_sequence();
        frame_gc = '{0, 0, 0};
        a_halves_sum = 0;
        t_halves_sum = 0;
        win_count = 0;
        emit_pos = 0;
        wr_idx = 0;
        rd_idx = 0;
        wr_frame = 0;
        rd_frame = 0;
        n_pending = 0;
        n_emitted = 0;
    endfunction

    function automatic void emit_window(bit last);
        t_window_result r;
        logic [3:0]     c;
        int unsigned    s, at;
        int             lvl;
        // drop the leaving nucleotide once the window is full on the left
        if (n_emitted >= live_half) begin
            c = base_ring[rd_idx];
            frame_gc[rd_frame] = dec_floor(frame_gc[rd_frame], gc_weight(c));
            a_halves_sum = dec_floor(a_halves_sum, a_weight(c));
            t_halves_sum = dec_floor(t_halves_sum, t_weight(c));
            win_count = dec_floor(win_count, 1);
            rd_idx = (rd_idx + 1) % RING_DEPTH;
            rd_frame = (rd_frame + 1) % 3;
        end
        s = frame_gc[0] + frame_gc[1] + frame_gc[2];
        at = a_halves_sum + t_halves_sum;
        lvl = (win_count != 0) ? int'((s * 2048) / win_count) - 4096 : -4096;
        r.position = emit_pos[POS_BITS-1:0];
        r.gc_level = lvl[15:0];
        r.frame0 = (win_count != 0) ? 16'((frame_gc[0] * 4096) / win_count) : '0;
        r.frame1 = (win_count != 0) ? 16'((frame_gc[1] * 4096) / win_count) : '0;
        r.frame2 = (win_count != 0) ? 16'((frame_gc[2] * 4096) / win_count) : '0;
        r.t_share = (at != 0) ? 15'((t_halves_sum * 16384) / at) : '0;
        r.a_share = (at != 0) ? 15'((a_halves_sum * 16384) / at) : '0;
        r.no_at = (at == 0);
        r.last = last;
        expected_q.push_back(r);
        emit_pos = (emit_pos + 1) % (1 << POS_BITS);
        if (n_emitted < 127) n_emitted++;
        if (n_pending != 0) n_pending--;
    endfunction

    function automatic void predict_base(logic [3:0] c, logic seq_end);
        int n;
        n = 0;
        // latch h on the first item of a sequence
        if (n_pending == 0 && n_emitted == 0) begin
            live_half = (half_reg < 1) ? 1 : ((half_reg > MAX_HALF) ? MAX_HALF : half_reg);
        end
        base_ring[wr_idx] = c;
        wr_idx = (wr_idx + 1) % RING_DEPTH;
        frame_gc[wr_frame] += gc_weight(c);
        a_halves_sum += a_weight(c);
        t_halves_sum += t_weight(c);
        win_count++;
        wr_frame = (wr_frame + 1) % 3;
        n_pending++;
        if (n_pending > live_half) begin
            emit_window(1'b0);
            n++;
        end
        if (seq_end) begin
            while (n_pending > 0 && n < 64) begin
                emit_window(n_pending == 1);
                n++;
            end
            clear_sequence();
        end
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_window_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_q.size() == 0) begin
                $error("result item at position %0d with none expected", o_position);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                check_field("position", e.position, o_position);
                check_field("gc_level", e.gc_level, o_gc_level);
                check_field("gc_frame_zero", e.frame0, o_gc_frame_zero);
                check_field("gc_frame_one", e.frame1, o_gc_frame_one);
                check_field("gc_frame_two", e.frame2, o_gc_frame_two);
                check_field("t_share", e.t_share, o_t_share);
                check_field("a_share", e.a_share, o_a_share);
                check_field("no_at", e.no_at, o_no_at);
                check_field("final_result", e.last, o_final_result);
            end
        end
    end

    // watchdog: cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= WDOG_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_base(logic [3:0] c, logic seq_end);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_base_code <= c;
        i_seq_end <= seq_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_base(c, seq_end);
    endtask

    // hold off until every expected item is back and the block is quiet
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_half(logic [5:0] h);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= h;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        half_reg = h;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sequence(int len);
        for (int k = 0; k < len; k++) begin
            send_base(4'($urandom_range(15)), k == len - 1);
        end
    endtask

    task automatic test_reset_half_all_codes();
        // reset h = 24; every mask, empty one included
        for (int k = 0; k < 16; k++) send_base(4'(k), k == 15);
        drain();
    endtask

    task automatic test_half_extremes();
        write_half(6'd0);
        send_base(4'b0000, 1'b0);
        send_base(4'b1111, 1'b0);
        send_base(4'b0110, 1'b1);
        drain();
        write_half(6'd1);
        send_base(4'b1001, 1'b1);
        drain();
        write_half(6'd63);
        send_base(4'b0001, 1'b0);
        send_base(4'b1000, 1'b1);
        drain();
    endtask

    task automatic test_write_mid_sequence();
        write_half(6'd2);
        for (int k = 0; k < 5; k++) send_base(4'($urandom_range(15)), 1'b0);
        drain();
        write_half(6'd5);
        for (int k = 0; k < 3; k++) send_base(4'($urandom_range(15)), k == 2);
        send_sequence(8);
        drain();
    endtask

    task automatic test_random_sequences(int n_items);
        int sent, len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(5))
                0: write_half(6'd63);
                1: write_half(6'd1);
                default: write_half(6'($urandom_range(63)));
            endcase
            len = ($urandom_range(7) == 0) ? $urandom_range(100, 160) : $urandom_range(1, 40);
            if (len > n_items - sent) len = n_items - sent;
            send_sequence(len);
            sent += len;
            drain();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_base_code = '0;
        i_seq_end = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        half_reg = HALF_RESET;
        live_half = HALF_RESET;
        clear_sequence();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 32;
        recv_idle_pct = 64;
        test_reset_half_all_codes();
        test_half_extremes();
        test_write_mid_sequence();
        test_random_sequences(137);
        send_idle_pct = 64;
        recv_idle_pct = 32;
        test_random_sequences(137);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_sequences(137);

        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
